// ===== src/dpb_pkg.sv =====
// ---------------------------------------------------------------------------
// dpb_pkg: shared types and constants for depth pixel back-projection
// Word layouts of the pixel and point channels, configuration register
// indexes and reset values, and the fixed-point widths of the datapath.
// ---------------------------------------------------------------------------
package dpb_pkg;

	// field widths
	localparam int DEPTH_BITS     = 16;
	localparam int PIX_INDEX_BITS = 12;
	localparam int COLOUR_BITS    = 8;
	localparam int COORD_BITS     = 24;
	localparam int POINT_Z_BITS   = 20;
	localparam int FRAC_BITS      = 4;

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CENTRE_BITS    = 16;
	localparam int INV_FOCAL_BITS = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INV_FOCAL_X = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INV_FOCAL_Y = 2'd3;

	localparam logic [CENTRE_BITS-1:0]    CENTER_X_RESET    = 16'd15352;
	localparam logic [CENTRE_BITS-1:0]    CENTER_Y_RESET    = 16'd8632;
	localparam logic [INV_FOCAL_BITS-1:0] INV_FOCAL_X_RESET = 24'd15520;
	localparam logic [INV_FOCAL_BITS-1:0] INV_FOCAL_Y_RESET = 24'd15520;

	// defaults for the index masking parameters
	localparam int COLUMN_BITS_DEFAULT = 12;
	localparam int ROW_BITS_DEFAULT    = 12;

	// datapath widths
	localparam int OFFSET_BITS = CENTRE_BITS;
	localparam int PROD1_BITS  = OFFSET_BITS + INV_FOCAL_BITS;
	localparam int PROD2_BITS  = PROD1_BITS + DEPTH_BITS;
	localparam int SCALE_SHIFT = 24;
	localparam int MAG_BITS    = PROD2_BITS - SCALE_SHIFT;

	localparam logic [COORD_BITS-1:0]  COORD_MAX   = 24'h7FFFFF;
	localparam logic [COORD_BITS-1:0]  COORD_MIN   = 24'h800000;
	localparam logic [COLOUR_BITS-1:0] ALPHA_OPAQUE = 8'hFF;

	// pixel word
	typedef struct packed {
		logic [DEPTH_BITS-1:0]     depth_mm;
		logic [PIX_INDEX_BITS-1:0] pixel_column;
		logic [PIX_INDEX_BITS-1:0] pixel_row;
		logic [COLOUR_BITS-1:0]    blue;
		logic [COLOUR_BITS-1:0]    green;
		logic [COLOUR_BITS-1:0]    red;
	} pixel_t;

	// point word
	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic [POINT_Z_BITS-1:0]      point_z;
		logic                         point_valid;
		logic [COLOUR_BITS-1:0]       out_blue;
		logic [COLOUR_BITS-1:0]       out_green;
		logic [COLOUR_BITS-1:0]       out_red;
		logic [COLOUR_BITS-1:0]       out_alpha;
	} point_t;

	// colour bytes carried down the pipeline
	typedef struct packed {
		logic [COLOUR_BITS-1:0] blue;
		logic [COLOUR_BITS-1:0] green;
		logic [COLOUR_BITS-1:0] red;
	} colour_t;

endpackage

// ===== src/depth_pixel_backprojection.sv =====
// ---------------------------------------------------------------------------
// depth_pixel_backprojection: pinhole back-projection of depth pixels
// Four-stage pipeline turning a depth pixel with colour into a 3-D point.
// ---------------------------------------------------------------------------
// Usage
// - pixel channel (pix_valid/pix_ready/pix_word): one depth pixel per word,
//   with column, row and BGR colour
// - point channel (pt_valid/pt_ready/pt_word): one point per pixel, x/y/z in
//   1/16 mm, colour with alpha, in the order the pixels came in
// - config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): centre and
//   reciprocal focal length registers, to be written by the user only while
//   the pipeline is empty (not enforced here); cfg_ready is always high
// - a pixel passes through the offset stage, the two multiplier stages (offset
//   times 1/f, then times depth) and the rounding stage, each one register
//   deep; one word per cycle is sustained while pt_ready is high
// - each stage has its own valid bit and moves up whenever the stage after
//   it is free, so a stalled receiver fills the bubbles first and pix_ready
//   falls only when all four stages hold a word
// - reset empties the pipeline and loads the default camera model
// ---------------------------------------------------------------------------
module depth_pixel_backprojection #(
	parameter int COLUMN_BITS = dpb_pkg::COLUMN_BITS_DEFAULT,
	parameter int ROW_BITS    = dpb_pkg::ROW_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pix_valid,
	output logic                                 pix_ready,
	input  dpb_pkg::pixel_t                      pix_word,
	output logic                                 pt_valid,
	input  logic                                 pt_ready,
	output dpb_pkg::point_t                      pt_word,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dpb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [dpb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import dpb_pkg::*;

	localparam int ColKeep = (COLUMN_BITS < PIX_INDEX_BITS) ? COLUMN_BITS : PIX_INDEX_BITS;
	localparam int RowKeep = (ROW_BITS < PIX_INDEX_BITS) ? ROW_BITS : PIX_INDEX_BITS;
	localparam logic [PIX_INDEX_BITS-1:0] ColMask =
		{PIX_INDEX_BITS{1'b1}} >> (PIX_INDEX_BITS - ColKeep);
	localparam logic [PIX_INDEX_BITS-1:0] RowMask =
		{PIX_INDEX_BITS{1'b1}} >> (PIX_INDEX_BITS - RowKeep);
	localparam logic [PROD2_BITS-1:0] RoundHalf = PROD2_BITS'(1) << (SCALE_SHIFT - 1);

	// configuration registers
	logic [CENTRE_BITS-1:0]    center_x_q, center_y_q;
	logic [INV_FOCAL_BITS-1:0] inv_focal_x_q, inv_focal_y_q;

	// pipeline registers
	logic                    valid_s1, valid_s2, valid_s3, valid_s4;
	logic [OFFSET_BITS-1:0]  off_x_s1, off_y_s1;
	logic                    neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	logic [DEPTH_BITS-1:0]   depth_s1, depth_s2, depth_s3;
	colour_t                 colour_s1, colour_s2, colour_s3;
	logic [PROD1_BITS-1:0]   prod_x_s2, prod_y_s2;
	logic [PROD2_BITS-1:0]   prod_x_s3, prod_y_s3;
	point_t                  point_s4;

	logic ready_s1, ready_s2, ready_s3, ready_s4;

	// offset stage inputs
	logic [CENTRE_BITS-1:0] pos_x, pos_y;
	logic                   neg_x, neg_y;
	logic [OFFSET_BITS-1:0] off_x, off_y;

	// rounding stage results
	logic [COORD_BITS-1:0] coord_x, coord_y;
	point_t                point_next;

	// round, shift, sign and saturate one axis
	function automatic logic [COORD_BITS-1:0] finish_axis(
		input logic [PROD2_BITS-1:0] prod,
		input logic                  neg
	);
		logic [PROD2_BITS-1:0] sum;
		logic [MAG_BITS-1:0]   mag;
		logic [COORD_BITS-1:0] res;
		sum = prod + RoundHalf;
		mag = sum[PROD2_BITS-1:SCALE_SHIFT];
		if (neg) begin
			if (mag >= MAG_BITS'(COORD_MIN))
				res = COORD_MIN;
			else
				res = (~mag[COORD_BITS-1:0]) + COORD_BITS'(1);
		end else begin
			if (mag > MAG_BITS'(COORD_MAX))
				res = COORD_MAX;
			else
				res = mag[COORD_BITS-1:0];
		end
		return res;
	endfunction

	// register writes, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= CENTER_X_RESET;
			center_y_q    <= CENTER_Y_RESET;
			inv_focal_x_q <= INV_FOCAL_X_RESET;
			inv_focal_y_q <= INV_FOCAL_Y_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_X:    center_x_q    <= cfg_data[CENTRE_BITS-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[CENTRE_BITS-1:0];
				REG_INV_FOCAL_X: inv_focal_x_q <= cfg_data;
				REG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-stage flow control
	assign ready_s4  = !valid_s4 || pt_ready;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign pix_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= pix_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: pixel offset from the principal point, sign and magnitude
	assign pos_x = {pix_word.pixel_column & ColMask, FRAC_BITS'(0)};
	assign pos_y = {pix_word.pixel_row & RowMask, FRAC_BITS'(0)};
	assign neg_x = pos_x < center_x_q;
	assign neg_y = pos_y < center_y_q;
	assign off_x = neg_x ? (center_x_q - pos_x) : (pos_x - center_x_q);
	assign off_y = neg_y ? (center_y_q - pos_y) : (pos_y - center_y_q);

	always_ff @(posedge clk) begin
		if (ready_s1 && pix_valid) begin
			off_x_s1  <= off_x;
			off_y_s1  <= off_y;
			neg_x_s1  <= neg_x;
			neg_y_s1  <= neg_y;
			depth_s1  <= pix_word.depth_mm;
			colour_s1 <= '{blue: pix_word.blue, green: pix_word.green, red: pix_word.red};
		end
	end

	// stage 2: offset times reciprocal focal length
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			prod_x_s2 <= PROD1_BITS'(off_x_s1) * PROD1_BITS'(inv_focal_x_q);
			prod_y_s2 <= PROD1_BITS'(off_y_s1) * PROD1_BITS'(inv_focal_y_q);
			neg_x_s2  <= neg_x_s1;
			neg_y_s2  <= neg_y_s1;
			depth_s2  <= depth_s1;
			colour_s2 <= colour_s1;
		end
	end

	// stage 3: times depth
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			prod_x_s3 <= PROD2_BITS'(prod_x_s2) * PROD2_BITS'(depth_s2);
			prod_y_s3 <= PROD2_BITS'(prod_y_s2) * PROD2_BITS'(depth_s2);
			neg_x_s3  <= neg_x_s2;
			neg_y_s3  <= neg_y_s2;
			depth_s3  <= depth_s2;
			colour_s3 <= colour_s2;
		end
	end

	// stage 4: rounding, saturation and invalid-point masking
	assign coord_x = finish_axis(prod_x_s3, neg_x_s3);
	assign coord_y = finish_axis(prod_y_s3, neg_y_s3);

	always_comb begin
		point_next = '0;
		if (depth_s3 != '0) begin
			point_next.point_x     = coord_x;
			point_next.point_y     = coord_y;
			point_next.point_z     = {depth_s3, FRAC_BITS'(0)};
			point_next.point_valid = 1'b1;
			point_next.out_blue    = colour_s3.blue;
			point_next.out_green   = colour_s3.green;
			point_next.out_red     = colour_s3.red;
			point_next.out_alpha   = ALPHA_OPAQUE;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3)
			point_s4 <= point_next;
	end

	assign pt_valid = valid_s4;
	assign pt_word  = point_s4;

	// checks
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("pixel channel blocked with a free pipeline stage");

	a_alpha_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid |-> ((pt_word.point_valid && pt_word.out_alpha == ALPHA_OPAQUE) ||
			(!pt_word.point_valid && pt_word.out_alpha == '0)))
		else $error("alpha does not follow the point valid flag");

	a_invalid_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && !pt_word.point_valid) |->
			(pt_word.point_x == '0 && pt_word.point_y == '0 && pt_word.point_z == '0))
		else $error("invalid point carries nonzero coordinates");

	a_z_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid |-> ((pt_word.point_z != '0) == pt_word.point_valid))
		else $error("depth and valid flag disagree");

endmodule
